/* hdl/cdd_pkg.sv */
// ----------------------------------------------------------------------------
// cdd_pkg
// shared types and codes for the circular deque with delete at index
// ----------------------------------------------------------------------------
package cdd_pkg;

  localparam int unsigned DEFAULT_CAPACITY = 16;

  localparam int unsigned REQ_W   = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned FILL_W  = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_DELETE     = 3'd2,
    REQ_READ_FWD   = 3'd3,
    REQ_READ_BWD   = 3'd4
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_EMPTY  = 2'd1,
    STATUS_BADPOS = 2'd2,
    STATUS_FULL   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_LINK,
    ST_DEL_WALK,
    ST_RD_WALK,
    ST_RESP
  } state_e;

endpackage

/* hdl/circular_deque_delete_at_index_core.sv */
// ----------------------------------------------------------------------------
// circular_deque_delete_at_index_core
// bounded circular doubly linked list of signed 32-bit values
// ----------------------------------------------------------------------------
// requests enter on the input channel (in_valid_i / in_stall_o) with req_type,
// value and position; results leave on the output channel (out_valid_o /
// out_stall_i) with status, element, fill_count and last.
// one request is worked on at a time; in_stall_o is high while it is busy.
// push: one result, via ST_RESP to the output register (via ST_PUSH_LINK first
// when the list was not empty, for the second link write). delete: one result,
// one link followed per cycle through the next-link memory. readout: first
// element read in the accept cycle, then one element per cycle while the
// receiver does not stall, paced by the registered value and link reads.
// push on a full list, delete on an empty list or past the end, and readout
// of an empty list answer with a single status beat.
// reset empties the list at once; the slot memories need no clearing pass.
// when the receiver stalls, the result waits in the output register and a
// readout walk pauses with its read data held.
// ----------------------------------------------------------------------------
module circular_deque_delete_at_index_core #(
  parameter int unsigned CAPACITY = cdd_pkg::DEFAULT_CAPACITY
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [cdd_pkg::REQ_W-1:0]    req_type_i,
  input  logic signed [cdd_pkg::VALUE_W-1:0] value_i,
  input  logic [cdd_pkg::POS_W-1:0]    position_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [cdd_pkg::STAT_W-1:0]   status_o,
  output logic signed [cdd_pkg::VALUE_W-1:0] element_o,
  output logic [cdd_pkg::FILL_W-1:0]   fill_count_o,
  output logic                         last_o
);

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > cdd_pkg::POS_W) ? CNT_W : cdd_pkg::POS_W;
  localparam int unsigned VW    = cdd_pkg::VALUE_W;

  cdd_pkg::state_e  state_q, state_d;
  cdd_pkg::status_e resp_q, resp_d;
  logic [AW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [AW-1:0]       cur_q, cur_d, new_q, new_d, steps_q, steps_d;
  logic [CNT_W-1:0]    count_q, count_d, remain_q, remain_d;
  logic [CAPACITY-1:0] used_q, used_d;
  logic                front_q, front_d, fwd_q, fwd_d;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          val_we, nxt_we, prv_we;
  logic [AW-1:0] val_waddr, nxt_waddr, prv_waddr;
  logic [VW-1:0] val_wdata, val_rdata;
  logic [AW-1:0] nxt_wdata, prv_wdata, nxt_rdata, prv_rdata;
  logic [AW-1:0] free_slot;

  logic                   emit, emit_last, out_free, out_load;
  cdd_pkg::status_e       emit_status;
  logic [VW-1:0]          emit_element;
  logic                   out_valid_q;
  logic [cdd_pkg::STAT_W-1:0] out_status_q;
  logic [VW-1:0]          out_element_q;
  logic [cdd_pkg::FILL_W-1:0] out_fill_q;
  logic                   out_last_q;
  logic                   in_accept;

  cdd_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (val_rdata)
  );

  cdd_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (nxt_rdata)
  );

  cdd_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prv_we),
    .waddr_i (prv_waddr),
    .wdata_i (prv_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (prv_rdata)
  );

  cdd_free_slot #(.CAPACITY(CAPACITY)) u_free_slot (
    .used_i (used_q),
    .slot_o (free_slot)
  );

  assign in_stall_o = (state_q != cdd_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = emit && out_free;

  // writes only happen in the accept cycle of a push, the push link cycle or
  // the last walk cycle of a delete, never while a walk reads, so no entry is
  // read and written at once
  always_comb begin
    state_d      = state_q;
    resp_d       = resp_q;
    head_d       = head_q;
    tail_d       = tail_q;
    cur_d        = cur_q;
    new_d        = new_q;
    steps_d      = steps_q;
    count_d      = count_q;
    remain_d     = remain_q;
    used_d       = used_q;
    front_d      = front_q;
    fwd_d        = fwd_q;
    rd_en        = 1'b0;
    rd_addr      = cur_q;
    val_we       = 1'b0;
    val_waddr    = free_slot;
    val_wdata    = value_i;
    nxt_we       = 1'b0;
    nxt_waddr    = free_slot;
    nxt_wdata    = head_q;
    prv_we       = 1'b0;
    prv_waddr    = free_slot;
    prv_wdata    = tail_q;
    emit         = 1'b0;
    emit_status  = cdd_pkg::STATUS_OK;
    emit_element = '0;
    emit_last    = 1'b0;

    case (state_q)
      cdd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (req_type_i)
            cdd_pkg::REQ_PUSH_FRONT, cdd_pkg::REQ_PUSH_BACK: begin
              state_d = cdd_pkg::ST_RESP;
              if (count_q == CNT_W'(CAPACITY)) begin
                resp_d = cdd_pkg::STATUS_FULL;
              end else begin
                resp_d           = cdd_pkg::STATUS_OK;
                val_we           = 1'b1;
                nxt_we           = 1'b1;
                prv_we           = 1'b1;
                used_d[free_slot] = 1'b1;
                count_d          = count_q + CNT_W'(1);
                new_d            = free_slot;
                front_d          = (req_type_i == cdd_pkg::REQ_PUSH_FRONT);
                if (count_q == '0) begin
                  // a lone element links to itself
                  nxt_wdata = free_slot;
                  prv_wdata = free_slot;
                  head_d    = free_slot;
                  tail_d    = free_slot;
                end else begin
                  state_d = cdd_pkg::ST_PUSH_LINK;
                end
              end
            end
            cdd_pkg::REQ_DELETE: begin
              if (count_q == '0) begin
                resp_d  = cdd_pkg::STATUS_EMPTY;
                state_d = cdd_pkg::ST_RESP;
              end else if (CMP_W'(position_i) >= CMP_W'(count_q)) begin
                resp_d  = cdd_pkg::STATUS_BADPOS;
                state_d = cdd_pkg::ST_RESP;
              end else begin
                rd_en   = 1'b1;
                rd_addr = head_q;
                cur_d   = head_q;
                steps_d = AW'(position_i);
                state_d = cdd_pkg::ST_DEL_WALK;
              end
            end
            cdd_pkg::REQ_READ_FWD, cdd_pkg::REQ_READ_BWD: begin
              if (count_q == '0) begin
                resp_d  = cdd_pkg::STATUS_EMPTY;
                state_d = cdd_pkg::ST_RESP;
              end else begin
                fwd_d    = (req_type_i == cdd_pkg::REQ_READ_FWD);
                rd_en    = 1'b1;
                rd_addr  = (req_type_i == cdd_pkg::REQ_READ_FWD) ? head_q : tail_q;
                remain_d = count_q;
                state_d  = cdd_pkg::ST_RD_WALK;
              end
            end
            default: begin
              // unknown request codes are dropped
            end
          endcase
        end
      end

      cdd_pkg::ST_PUSH_LINK: begin
        nxt_we    = 1'b1;
        nxt_waddr = tail_q;
        nxt_wdata = new_q;
        prv_we    = 1'b1;
        prv_waddr = head_q;
        prv_wdata = new_q;
        if (front_q) begin
          head_d = new_q;
        end else begin
          tail_d = new_q;
        end
        state_d = cdd_pkg::ST_RESP;
      end

      cdd_pkg::ST_DEL_WALK: begin
        if (steps_q == '0) begin
          // links of cur_q are in the read data: unlink it
          used_d[cur_q] = 1'b0;
          count_d       = count_q - CNT_W'(1);
          resp_d        = cdd_pkg::STATUS_OK;
          state_d       = cdd_pkg::ST_RESP;
          if (count_q == CNT_W'(1)) begin
            head_d = '0;
            tail_d = '0;
          end else begin
            nxt_we    = 1'b1;
            nxt_waddr = prv_rdata;
            nxt_wdata = nxt_rdata;
            prv_we    = 1'b1;
            prv_waddr = nxt_rdata;
            prv_wdata = prv_rdata;
            if (cur_q == head_q) begin
              head_d = nxt_rdata;
            end
            if (cur_q == tail_q) begin
              tail_d = prv_rdata;
            end
          end
        end else begin
          steps_d = steps_q - AW'(1);
          rd_en   = 1'b1;
          rd_addr = nxt_rdata;
          cur_d   = nxt_rdata;
        end
      end

      cdd_pkg::ST_RD_WALK: begin
        emit         = 1'b1;
        emit_element = val_rdata;
        emit_last    = (remain_q == CNT_W'(1));
        if (out_free) begin
          if (remain_q == CNT_W'(1)) begin
            state_d = cdd_pkg::ST_IDLE;
          end else begin
            remain_d = remain_q - CNT_W'(1);
            rd_en    = 1'b1;
            rd_addr  = fwd_q ? nxt_rdata : prv_rdata;
          end
        end
      end

      cdd_pkg::ST_RESP: begin
        emit        = 1'b1;
        emit_status = resp_q;
        emit_last   = 1'b1;
        if (out_free) begin
          state_d = cdd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = cdd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= cdd_pkg::ST_IDLE;
      resp_q   <= cdd_pkg::STATUS_OK;
      head_q   <= '0;
      tail_q   <= '0;
      cur_q    <= '0;
      new_q    <= '0;
      steps_q  <= '0;
      count_q  <= '0;
      remain_q <= '0;
      used_q   <= '0;
      front_q  <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      resp_q   <= resp_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      cur_q    <= cur_d;
      new_q    <= new_d;
      steps_q  <= steps_d;
      count_q  <= count_d;
      remain_q <= remain_d;
      used_q   <= used_d;
      front_q  <= front_d;
      fwd_q    <= fwd_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q  <= emit_status;
      out_element_q <= emit_element;
      out_fill_q    <= cdd_pkg::FILL_W'(count_q);
      out_last_q    <= emit_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign element_o    = out_element_q;
  assign fill_count_o = out_fill_q;
  assign last_o       = out_last_q;

  a_count_matches_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) == int'(count_q))
    else $error("element count differs from occupied slots");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (req_type_i == cdd_pkg::REQ_PUSH_FRONT ||
                   req_type_i == cdd_pkg::REQ_PUSH_BACK) &&
     count_q != CNT_W'(CAPACITY))
    |=> count_q == CNT_W'($past(count_q) + CNT_W'(1)))
    else $error("push did not add one element");

  a_last_ends_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && emit_last) |=> state_q == cdd_pkg::ST_IDLE)
    else $error("final beat did not return to idle");

  a_readout_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cdd_pkg::ST_RD_WALK) |-> (remain_q != '0 && remain_q <= count_q))
    else $error("readout beats out of range");

  a_walk_on_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cdd_pkg::ST_DEL_WALK) |-> used_q[cur_q])
    else $error("delete walk reached a free slot");

endmodule

/* hdl/cdd_ram.sv */
// ----------------------------------------------------------------------------
// cdd_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module cdd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/cdd_free_slot.sv */
// ----------------------------------------------------------------------------
// cdd_free_slot
// finds the lowest free slot from the occupancy bits
// ----------------------------------------------------------------------------
module cdd_free_slot #(
  parameter int unsigned CAPACITY = cdd_pkg::DEFAULT_CAPACITY
) (
  input  logic [CAPACITY-1:0]         used_i,
  output logic [$clog2(CAPACITY)-1:0] slot_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  logic [CAPACITY-1:0] free;
  logic [CAPACITY-1:0] lowest;
  logic [AW-1:0]       slot;

  // isolate the lowest set bit of the free mask
  assign free   = ~used_i;
  assign lowest = free & (~free + CAPACITY'(1));

  always_comb begin
    slot = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (lowest[i]) begin
        slot = slot | AW'(i);
      end
    end
  end

  assign slot_o = slot;

endmodule
